/* rtl/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants of the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int N_ENT     = 9;
	localparam int OUT_W     = 16;
	localparam int Q_W       = 16;
	localparam int DIV_STEPS = 16;
	localparam logic [OUT_W-1:0] ONE_Q214 = 16'd16384;

	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [N_ENT-1:0] neg;
	} qrm_ctrl_t;

endpackage

/* rtl/qrm_numer.sv */
// ----------------------------------------------------------------------------
// qrm_numer
// Three stages: component products, matrix numerators and squared norm,
// then sign and magnitude of each numerator.
// ----------------------------------------------------------------------------
module qrm_numer #(
	parameter int W = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [W-1:0]       qw,
	input  logic signed [W-1:0]       qx,
	input  logic signed [W-1:0]       qy,
	input  logic signed [W-1:0]       qz,
	output qrm_pkg::qrm_ctrl_t        ctrl_s3,
	output logic [2*W+1:0]            mag_s3 [qrm_pkg::N_ENT],
	output logic [2*W+1:0]            den_s3
);
	import qrm_pkg::*;

	localparam int PW = 2 * W;
	localparam int DW = 2 * W + 2;

	logic                 v_s1, v_s2;
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, zw_s1, xz_s1, yw_s1, yz_s1, xw_s1;
	logic signed [DW-1:0] num_s2 [N_ENT];
	logic signed [DW-1:0] n2_s2;
	logic signed [DW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_zw, e_xz, e_yw, e_yz, e_xw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			ctrl_s3 <= '0;
		end else if (en) begin
			v_s1          <= in_valid;
			v_s2          <= v_s1;
			ctrl_s3.valid <= v_s2;
			ctrl_s3.zero  <= (n2_s2 == '0);
			for (int i = 0; i < N_ENT; i++) ctrl_s3.neg[i] <= num_s2[i][DW-1];
		end
	end

	always_comb begin
		e_ww = DW'(ww_s1); e_xx = DW'(xx_s1); e_yy = DW'(yy_s1); e_zz = DW'(zz_s1);
		e_xy = DW'(xy_s1); e_zw = DW'(zw_s1); e_xz = DW'(xz_s1); e_yw = DW'(yw_s1);
		e_yz = DW'(yz_s1); e_xw = DW'(xw_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= qw * qw; xx_s1 <= qx * qx; yy_s1 <= qy * qy; zz_s1 <= qz * qz;
			xy_s1 <= qx * qy; zw_s1 <= qz * qw; xz_s1 <= qx * qz;
			yw_s1 <= qy * qw; yz_s1 <= qy * qz; xw_s1 <= qx * qw;

			n2_s2     <= (e_ww + e_xx) + (e_yy + e_zz);
			num_s2[0] <= (e_ww + e_xx) - (e_yy + e_zz);
			num_s2[1] <= (e_xy - e_zw) <<< 1;
			num_s2[2] <= (e_xz + e_yw) <<< 1;
			num_s2[3] <= (e_xy + e_zw) <<< 1;
			num_s2[4] <= (e_ww + e_yy) - (e_xx + e_zz);
			num_s2[5] <= (e_yz - e_xw) <<< 1;
			num_s2[6] <= (e_xz - e_yw) <<< 1;
			num_s2[7] <= (e_yz + e_xw) <<< 1;
			num_s2[8] <= (e_ww + e_zz) - (e_xx + e_yy);

			den_s3 <= n2_s2;
			for (int i = 0; i < N_ENT; i++)
				mag_s3[i] <= num_s2[i][DW-1] ? -num_s2[i] : num_s2[i];
		end
	end

endmodule

/* rtl/qrm_div_step.sv */
// ----------------------------------------------------------------------------
// qrm_div_step
// One registered restoring-division step for all nine entries, sharing
// the squared norm as divisor.
// ----------------------------------------------------------------------------
module qrm_div_step #(
	parameter int DW    = 34,
	parameter bit FIRST = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  qrm_pkg::qrm_ctrl_t     ctrl_i,
	input  logic [DW-1:0]          den_i,
	input  logic [DW-1:0]          r_i [qrm_pkg::N_ENT],
	input  logic [qrm_pkg::Q_W-1:0] q_i [qrm_pkg::N_ENT],
	output qrm_pkg::qrm_ctrl_t     ctrl_o,
	output logic [DW-1:0]          den_o,
	output logic [DW-1:0]          r_o [qrm_pkg::N_ENT],
	output logic [qrm_pkg::Q_W-1:0] q_o [qrm_pkg::N_ENT]
);
	import qrm_pkg::*;

	logic [DW-1:0] rs [N_ENT];
	logic          ge [N_ENT];

	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			rs[i] = FIRST ? r_i[i] : {r_i[i][DW-2:0], 1'b0};
			ge[i] = (rs[i] >= den_i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			for (int i = 0; i < N_ENT; i++) begin
				r_o[i] <= ge[i] ? rs[i] - den_i : rs[i];
				q_o[i] <= {q_i[i][Q_W-2:0], ge[i]};
			end
		end
	end

endmodule

/* rtl/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalized quaternion to 3x3 rotation matrix, signed Q2.14 entries.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one quaternion per item (w, x, y, z, each
//   COMPONENT_WIDTH bits, two's complement). Master channel m_* returns the
//   nine entries r00..r22 in tdata and the zero-norm flag in tuser.
//   Each entry is N / |q|^2, rounded to nearest (ties away from zero) and
//   clamped to +-1.0; an all-zero quaternion gives zero entries and the flag.
//   The pipeline has three stages for products, numerators and sign,
//   sixteen restoring-division stages sharing the squared norm, and one
//   rounding stage that is the output register.
//   Throughput is one item per cycle while the receiver does not stall. The whole pipeline advances when the
//   output register is empty or taken; when the receiver stalls every stage
//   holds and s_tready drops, so nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// quat_w, quat_x, quat_y, quat_z (zero padded to bytes)
	input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22
	output logic [qrm_pkg::N_ENT*qrm_pkg::OUT_W-1:0]   m_tdata,
	// zero_norm
	output logic [0:0]                                 m_tuser
);
	import qrm_pkg::*;

	localparam int W  = COMPONENT_WIDTH;
	localparam int DW = 2 * W + 2;

	logic            adv;
	qrm_ctrl_t       ctrl_c [DIV_STEPS+1];
	logic [DW-1:0]   den_c  [DIV_STEPS+1];
	logic [DW-1:0]   r_c    [DIV_STEPS+1][N_ENT];
	logic [Q_W-1:0]  q_c    [DIV_STEPS+1][N_ENT];
	logic [OUT_W-1:0] ent   [N_ENT];
	logic [Q_W:0]    rnd    [N_ENT];
	logic [OUT_W-1:0] sat   [N_ENT];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	qrm_numer #(.W(W)) u_numer (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_valid(s_tvalid),
		.qw      (s_tdata[W-1:0]),
		.qx      (s_tdata[2*W-1:W]),
		.qy      (s_tdata[3*W-1:2*W]),
		.qz      (s_tdata[4*W-1:3*W]),
		.ctrl_s3 (ctrl_c[0]),
		.mag_s3  (r_c[0]),
		.den_s3  (den_c[0])
	);

	always_comb begin
		for (int i = 0; i < N_ENT; i++) q_c[0][i] = '0;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		qrm_div_step #(.DW(DW), .FIRST(k == 0)) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctrl_i(ctrl_c[k]),
			.den_i (den_c[k]),
			.r_i   (r_c[k]),
			.q_i   (q_c[k]),
			.ctrl_o(ctrl_c[k+1]),
			.den_o (den_c[k+1]),
			.r_o   (r_c[k+1]),
			.q_o   (q_c[k+1])
		);
	end

	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			rnd[i] = ({1'b0, q_c[DIV_STEPS][i]} + 17'd1) >> 1;
			sat[i] = (rnd[i] > {1'b0, ONE_Q214}) ? ONE_Q214 : rnd[i][OUT_W-1:0];
			if (ctrl_c[DIV_STEPS].zero)
				ent[i] = '0;
			else if (ctrl_c[DIV_STEPS].neg[i])
				ent[i] = -sat[i];
			else
				ent[i] = sat[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= ctrl_c[DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_ENT; i++) m_tdata[i*OUT_W +: OUT_W] <= ent[i];
			m_tuser[0] <= ctrl_c[DIV_STEPS].zero;
		end
	end

endmodule
